[rtl/core/smrs_pkg.sv]
// ============================================================================
// smrs_pkg
// Shared types and constants of the serial mouse report shifter.
// ============================================================================
package smrs_pkg;

    localparam int DeltaWidth   = 16;
    localparam int MagWidth     = 7;
    localparam int CountWidth   = 6;
    localparam int SpeedWidth   = 2;

    localparam logic [MagWidth-1:0]   MagMax     = 7'd127;
    localparam logic [CountWidth-1:0] ReportBits = 6'd32;

    localparam logic FuncLatch = 1'b0;
    localparam logic FuncRead  = 1'b1;

    localparam logic [SpeedWidth-1:0] SpeedX1  = 2'd0;
    localparam logic [SpeedWidth-1:0] SpeedX15 = 2'd1;
    localparam logic [SpeedWidth-1:0] SpeedX2  = 2'd2;

    typedef logic signed [DeltaWidth-1:0] delta_t;
    typedef logic [MagWidth-1:0]          mag_t;
    typedef logic [SpeedWidth-1:0]        speed_t;
    typedef logic [CountWidth-1:0]        count_t;

    typedef struct packed {
        logic dir;
        mag_t mag;
    } axis_t;

endpackage

[rtl/core/smrs_in_if.sv]
// ============================================================================
// smrs_in_if
// Handshake channel that carries one latch write or serial read item.
// ============================================================================
interface smrs_in_if;
    import smrs_pkg::*;

    logic   valid;
    logic   ready;
    logic   func;
    logic   latch_level;
    delta_t delta_x;
    delta_t delta_y;
    logic   button_left;
    logic   button_right;

    modport source (
        output valid, func, latch_level, delta_x, delta_y, button_left, button_right,
        input  ready
    );

    modport sink (
        input  valid, func, latch_level, delta_x, delta_y, button_left, button_right,
        output ready
    );
endinterface

[rtl/core/smrs_out_if.sv]
// ============================================================================
// smrs_out_if
// Handshake channel that carries one serial data bit item.
// ============================================================================
interface smrs_out_if;
    logic valid;
    logic ready;
    logic serial_bit;

    modport source (
        output valid, serial_bit,
        input  ready
    );

    modport sink (
        input  valid, serial_bit,
        output ready
    );
endinterface

[rtl/core/serial_mouse_report_shifter_top.sv]
// ============================================================================
// serial_mouse_report_shifter_top
// Game-port mouse: latch capture, speed stepping and 32-bit serial report.
// ============================================================================
//   Channel  Direction  Payload
//   cmd      in         func, latch_level, delta_x, delta_y, button_left,
//                       button_right
//   rsp      out        serial_bit (one item per read, none per latch write)
//
// A read's bit sits in the output register in the next cycle, and an item can
// be accepted in every cycle unless a stall on rsp holds cmd.
// The state update and bit selection are one pass of logic into the registers.
// Reset clears all state but the output bit register. A stall on rsp holds cmd
// only while the output register is full and not being taken.
// ============================================================================
module serial_mouse_report_shifter_top (
    input  logic       clk,
    input  logic       rst_n,
    smrs_in_if.sink    cmd,
    smrs_out_if.source rsp
);
    import smrs_pkg::*;

    logic   latch_state_reg, latch_state_next;
    count_t bit_counter_reg, bit_counter_next;
    speed_t speed_reg, speed_next;
    axis_t  axis_x_reg, axis_x_next;
    axis_t  axis_y_reg, axis_y_next;
    logic [1:0] buttons_reg, buttons_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_bit_reg, out_bit_next;

    logic   fire;
    logic   report_bit;
    logic [4:0] idx;
    logic [4:0] ofs_y;
    logic [4:0] ofs_x;

    function automatic axis_t axis_capture(delta_t delta, speed_t speed);
        logic [DeltaWidth:0]   m;
        logic [DeltaWidth+1:0] s;
        axis_t r;
        m = delta[DeltaWidth-1] ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
        case (speed)
            SpeedX15: s = {1'b0, m} + {2'b00, m[DeltaWidth:1]};
            SpeedX2:  s = {m, 1'b0};
            default:  s = {1'b0, m};
        endcase
        r.dir = delta[DeltaWidth-1];
        r.mag = (s > {11'd0, MagMax}) ? MagMax : s[MagWidth-1:0];
        return r;
    endfunction

    assign cmd.ready      = !out_valid_reg || rsp.ready;
    assign fire           = cmd.valid && cmd.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.serial_bit = out_bit_reg;

    assign idx   = bit_counter_reg[4:0];
    assign ofs_y = 5'd23 - idx;
    assign ofs_x = 5'd31 - idx;

    always_comb
    begin
        case (idx)
            5'd8:    report_bit = buttons_reg[1];
            5'd9:    report_bit = buttons_reg[0];
            5'd10:   report_bit = speed_reg[1];
            5'd11:   report_bit = speed_reg[0];
            5'd12, 5'd13, 5'd14: report_bit = 1'b0;
            5'd15:   report_bit = 1'b1;
            5'd16:   report_bit = axis_y_reg.dir;
            5'd24:   report_bit = axis_x_reg.dir;
            default:
            begin
                if (idx < 5'd8)
                    report_bit = 1'b0;
                else if (idx < 5'd24)
                    report_bit = axis_y_reg.mag[ofs_y[2:0]];
                else
                    report_bit = axis_x_reg.mag[ofs_x[2:0]];
            end
        endcase
    end

    always_comb
    begin
        latch_state_next = latch_state_reg;
        bit_counter_next = bit_counter_reg;
        speed_next       = speed_reg;
        axis_x_next      = axis_x_reg;
        axis_y_next      = axis_y_reg;
        buttons_next     = buttons_reg;
        out_valid_next   = rsp.ready ? 1'b0 : out_valid_reg;
        out_bit_next     = out_bit_reg;

        if (fire)
        begin
            if (cmd.func == FuncLatch)
            begin
                if (cmd.latch_level != latch_state_reg)
                begin
                    latch_state_next = cmd.latch_level;
                    bit_counter_next = '0;
                    axis_x_next      = axis_capture(cmd.delta_x, speed_reg);
                    axis_y_next      = axis_capture(cmd.delta_y, speed_reg);
                    buttons_next     = {cmd.button_right, cmd.button_left};
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                if (latch_state_reg)
                begin
                    speed_next   = (speed_reg >= SpeedX2) ? SpeedX1 : speed_reg + 2'd1;
                    out_bit_next = 1'b0;
                end
                else if (bit_counter_reg >= ReportBits)
                begin
                    bit_counter_next = ReportBits;
                    out_bit_next     = 1'b1;
                end
                else
                begin
                    bit_counter_next = bit_counter_reg + 6'd1;
                    out_bit_next     = report_bit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_state_reg <= 1'b0;
            bit_counter_reg <= '0;
            speed_reg       <= SpeedX1;
            axis_x_reg      <= '0;
            axis_y_reg      <= '0;
            buttons_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            latch_state_reg <= latch_state_next;
            bit_counter_reg <= bit_counter_next;
            speed_reg       <= speed_next;
            axis_x_reg      <= axis_x_next;
            axis_y_reg      <= axis_y_next;
            buttons_reg     <= buttons_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
    end

endmodule
